[sv/dip_pkg.sv]
// Shared types, character codes and helper functions of the dotted IPv4 address parser.
package dip_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;

    localparam logic [4:0] DIGIT_NONE = 5'd16;
    localparam logic [4:0] DIGIT_MAX_OCT = 5'd7;
    localparam logic [4:0] DIGIT_MAX_DEC = 5'd9;
    localparam logic [4:0] DIGIT_MAX_HEX = 5'd15;

    localparam logic [31:0] LIMIT_24 = 32'h00ff_ffff;
    localparam logic [31:0] LIMIT_16 = 32'h0000_ffff;
    localparam logic [31:0] LIMIT_8  = 32'h0000_00ff;
    localparam int          MAX_PARTS_BEFORE = 3;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_ZERO   = 2'd1,
        PH_PREFIX = 2'd2,
        PH_DIGITS = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } t_base;

    typedef struct packed {
        logic [2:0][31:0] parts;
        logic [32:0]      value;
        logic [1:0]       count;
        t_phase           phase;
        t_base            base;
        logic             error;
        logic             ended;
    } t_scan_state;

    typedef struct packed {
        logic [31:0] address;
        logic        ok;
    } t_pack_result;

    function automatic logic [4:0] dip_digit(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 5'(c - CH_ZERO);
        end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            d = 5'(c - CH_LOW_A + 8'd10);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            d = 5'(c - CH_UP_A + 8'd10);
        end
        return d;
    endfunction

    function automatic logic dip_is_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

[sv/dip_char_if.sv]
// Character input channel: valid, ready and one text byte.
interface dip_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

[sv/dip_addr_if.sv]
// Result output channel: valid, ready, packed address and success flag.
interface dip_addr_if;
    logic        valid;
    logic        ready;
    logic [31:0] address;
    logic        valid_res;

    modport source (output valid, output address, output valid_res, input ready);
    modport sink (input valid, input address, input valid_res, output ready);
endinterface

[sv/dotted_ipv4_address_parser_top.sv]
// Top level of the dotted IPv4 address parser: input register, scanner, packer, result register.
//
// The block takes one character of address text per transaction and accepts a new character
// in every cycle while no NUL is waiting. Each character is held in the input register and then
// updates the parse state; a NUL character produces exactly one result transaction, held in the
// result register, and the parser starts over with the next character. Only a NUL is stalled
// while an earlier result has not yet been taken, since the single result register is then
// occupied; other characters are held only while they queue behind such a stalled NUL.
module dotted_ipv4_address_parser_top
    import dip_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    dip_char_if.sink        i_char,
    dip_addr_if.source      o_addr
);

    logic         r_in_valid;
    logic [7:0]   r_in_char;
    logic         r_out_valid;
    logic [31:0]  r_out_address;
    logic         r_out_ok;
    logic         w_is_nul;
    logic         w_proc;
    t_scan_state  w_state;
    t_pack_result w_result;

    assign w_is_nul = (r_in_char == CH_NUL);
    assign w_proc   = r_in_valid && (!w_is_nul || !r_out_valid || o_addr.ready);
    assign i_char.ready = !r_in_valid || w_proc;

    dip_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_proc),
        .i_char  (r_in_char),
        .o_state (w_state)
    );

    dip_pack u_pack (
        .i_state  (w_state),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            if (w_proc && w_is_nul) begin
                r_out_valid <= 1'b1;
            end else if (o_addr.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_in_char <= i_char.char_code;
        end
        if (w_proc && w_is_nul) begin
            r_out_address <= w_result.address;
            r_out_ok      <= w_result.ok;
        end
    end

    assign o_addr.valid     = r_out_valid;
    assign o_addr.address   = r_out_address;
    assign o_addr.valid_res = r_out_ok;

endmodule

[sv/dip_scan.sv]
// Per-character scanner that keeps the parse state of the address being read.
module dip_scan
    import dip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_char,
    output t_scan_state o_state
);

    t_scan_state r_st;
    t_scan_state n_st;
    logic [4:0]  w_digit;
    logic [36:0] w_scaled;
    logic [36:0] w_sum;
    logic [32:0] w_acc;
    logic        w_digit_ok;

    assign w_digit = dip_digit(i_char);

    always_comb begin
        case (r_st.base)
            BASE_OCT: begin
                w_scaled   = {4'd0, r_st.value} << 3;
                w_digit_ok = (w_digit <= DIGIT_MAX_OCT);
            end
            BASE_HEX: begin
                w_scaled   = {4'd0, r_st.value} << 4;
                w_digit_ok = (w_digit <= DIGIT_MAX_HEX);
            end
            BASE_DEC: begin
                w_scaled   = ({4'd0, r_st.value} << 3) + ({4'd0, r_st.value} << 1);
                w_digit_ok = (w_digit <= DIGIT_MAX_DEC);
            end
            default: begin
                w_scaled   = ({4'd0, r_st.value} << 3) + ({4'd0, r_st.value} << 1);
                w_digit_ok = 1'b0;
            end
        endcase
        w_sum = w_scaled + {32'd0, w_digit};
        w_acc = (w_sum[36:32] != 5'd0) ? {1'b1, 32'd0} : {1'b0, w_sum[31:0]};
    end

    always_comb begin
        n_st = r_st;
        if (i_step) begin
            if (i_char == CH_NUL) begin
                n_st = '0;
            end else if (r_st.error || r_st.ended) begin
                n_st = r_st;
            end else if (dip_is_white(i_char)) begin
                if (r_st.phase == PH_ZERO || r_st.phase == PH_DIGITS) begin
                    n_st.ended = 1'b1;
                end else if (r_st.phase != PH_START) begin
                    n_st.error = 1'b1;
                end
            end else if (i_char == CH_DOT || i_char == CH_COLON) begin
                if ((r_st.phase != PH_ZERO && r_st.phase != PH_DIGITS) ||
                    r_st.count == 2'(MAX_PARTS_BEFORE) || r_st.value[32]) begin
                    n_st.error = 1'b1;
                end else begin
                    n_st.parts[r_st.count] = r_st.value[31:0];
                    n_st.count = r_st.count + 2'd1;
                    n_st.value = '0;
                    n_st.phase = PH_START;
                    n_st.base  = BASE_DEC;
                end
            end else begin
                unique case (r_st.phase)
                    PH_START: begin
                        if (w_digit == 5'd0) begin
                            n_st.phase = PH_ZERO;
                            n_st.base  = BASE_OCT;
                            n_st.value = '0;
                        end else if (w_digit <= DIGIT_MAX_DEC) begin
                            n_st.phase = PH_DIGITS;
                            n_st.base  = BASE_DEC;
                            n_st.value = {28'd0, w_digit};
                        end else begin
                            n_st.error = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        if (i_char == CH_LOW_X || i_char == CH_UP_X) begin
                            n_st.phase = PH_PREFIX;
                            n_st.base  = BASE_HEX;
                        end else if (w_digit <= DIGIT_MAX_OCT) begin
                            n_st.phase = PH_DIGITS;
                            n_st.value = {28'd0, w_digit};
                        end else begin
                            n_st.error = 1'b1;
                        end
                    end
                    PH_PREFIX: begin
                        if (w_digit <= DIGIT_MAX_HEX) begin
                            n_st.phase = PH_DIGITS;
                            n_st.value = {28'd0, w_digit};
                        end else begin
                            n_st.error = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        if (w_digit_ok) begin
                            n_st.value = w_acc;
                        end else begin
                            n_st.error = 1'b1;
                        end
                    end
                    default: begin
                        n_st.error = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_state = r_st;

endmodule

[sv/dip_pack.sv]
// Final check and packing of the parsed parts into one 32-bit address.
module dip_pack
    import dip_pkg::*;
(
    input  t_scan_state  i_state,
    output t_pack_result o_result
);

    logic [31:0] w_v;
    logic [31:0] w_p0;
    logic [31:0] w_p1;
    logic [31:0] w_p2;
    logic        w_ok;
    logic [31:0] w_addr;

    assign w_v  = i_state.value[31:0];
    assign w_p0 = i_state.parts[0];
    assign w_p1 = i_state.parts[1];
    assign w_p2 = i_state.parts[2];

    always_comb begin
        w_ok   = !i_state.error && !i_state.value[32] &&
                 (i_state.phase == PH_ZERO || i_state.phase == PH_DIGITS);
        w_addr = w_v;
        case (i_state.count)
            2'd0: begin
                w_addr = w_v;
            end
            2'd1: begin
                if (w_v > LIMIT_24 || w_p0 > LIMIT_8) begin
                    w_ok = 1'b0;
                end
                w_addr = w_v | {w_p0[7:0], 24'd0};
            end
            2'd2: begin
                if (w_v > LIMIT_16 || w_p0 > LIMIT_8 || w_p1 > LIMIT_8) begin
                    w_ok = 1'b0;
                end
                w_addr = w_v | {w_p0[7:0], w_p1[7:0], 16'd0};
            end
            default: begin
                if (w_v > LIMIT_8 || w_p0 > LIMIT_8 || w_p1 > LIMIT_8 || w_p2 > LIMIT_8) begin
                    w_ok = 1'b0;
                end
                w_addr = w_v | {w_p0[7:0], w_p1[7:0], w_p2[7:0], 8'd0};
            end
        endcase
        o_result.ok      = w_ok;
        o_result.address = w_ok ? w_addr : 32'd0;
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the dotted IPv4 address parser, with its own scanner model.
module testbench
    import dip_pkg::*;
();

    localparam int MAX_GAP     = 18;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dip_char_if char_if();
    dip_addr_if addr_if();

    dotted_ipv4_address_parser_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_addr  (addr_if)
    );

    t_pack_result expected_results[$];
    int           mismatch_count = 0;
    int           chars_sent = 0;
    int           quiet_cycles = 0;
    int           hold_off_cycles = 0;
    bit           src_pace_on = 1'b1;
    bit           snk_pace_on = 1'b1;

    logic [31:0]  held_parts [3];
    logic [32:0]  part_value;
    logic [1:0]   parts_done;
    t_phase       cur_phase;
    t_base        cur_base;
    logic         bad_text;
    logic         text_over;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void clear_scanner();
        for (int i = 0; i < 3; i++) begin
            held_parts[i] = '0;
        end
        part_value = '0;
        parts_done = '0;
        cur_phase  = PH_START;
        cur_base   = BASE_DEC;
        bad_text   = 1'b0;
        text_over  = 1'b0;
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            return int'(c) - int'(CH_ZERO);
        end
        if (c inside {[CH_LOW_A:CH_LOW_F]}) begin
            return int'(c) - int'(CH_LOW_A) + 10;
        end
        if (c inside {[CH_UP_A:CH_UP_F]}) begin
            return int'(c) - int'(CH_UP_A) + 10;
        end
        return 16;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int top_digit(input t_base b);
        case (b)
            BASE_OCT: return 7;
            BASE_HEX: return 15;
            default:  return 9;
        endcase
    endfunction

    function automatic int unsigned radix_of(input t_base b);
        case (b)
            BASE_OCT: return 8;
            BASE_HEX: return 16;
            default:  return 10;
        endcase
    endfunction

    function automatic void add_digit(input int digit);
        longint unsigned grown;
        grown = longint'(part_value) * radix_of(cur_base) + digit;
        part_value = (grown > 64'hFFFF_FFFF) ? 33'h1_0000_0000 : grown[32:0];
    endfunction

    function automatic t_pack_result pack_address();
        t_pack_result r;
        logic         ok;
        logic [31:0]  addr;
        ok = !bad_text && (cur_phase == PH_ZERO || cur_phase == PH_DIGITS) && !part_value[32];
        addr = part_value[31:0];
        if (ok) begin
            case (parts_done)
                2'd0: ;
                2'd1: begin
                    if (part_value > LIMIT_24 || held_parts[0] > LIMIT_8) ok = 1'b0;
                    else addr |= held_parts[0] << 24;
                end
                2'd2: begin
                    if (part_value > LIMIT_16 || held_parts[0] > LIMIT_8 ||
                        held_parts[1] > LIMIT_8) ok = 1'b0;
                    else addr |= (held_parts[0] << 24) | (held_parts[1] << 16);
                end
                default: begin
                    if (part_value > LIMIT_8 || held_parts[0] > LIMIT_8 ||
                        held_parts[1] > LIMIT_8 || held_parts[2] > LIMIT_8) ok = 1'b0;
                    else addr |= (held_parts[0] << 24) | (held_parts[1] << 16) |
                                 (held_parts[2] << 8);
                end
            endcase
        end
        r.address = ok ? addr : 32'd0;
        r.ok      = ok;
        return r;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        int digit;
        if (c == CH_NUL) begin
            expected_results.push_back(pack_address());
            clear_scanner();
            return;
        end
        if (bad_text || text_over) return;
        if (is_blank(c)) begin
            if (cur_phase == PH_ZERO || cur_phase == PH_DIGITS) text_over = 1'b1;
            else if (cur_phase != PH_START) bad_text = 1'b1;
            return;
        end
        if (c == CH_DOT || c == CH_COLON) begin
            if (!(cur_phase == PH_ZERO || cur_phase == PH_DIGITS) ||
                parts_done == 2'(MAX_PARTS_BEFORE) || part_value[32]) begin
                bad_text = 1'b1;
            end else begin
                held_parts[parts_done] = part_value[31:0];
                parts_done++;
                part_value = '0;
                cur_phase  = PH_START;
                cur_base   = BASE_DEC;
            end
            return;
        end
        digit = hex_value(c);
        case (cur_phase)
            PH_START: begin
                if (digit == 0) begin
                    cur_phase  = PH_ZERO;
                    cur_base   = BASE_OCT;
                    part_value = '0;
                end else if (digit <= 9) begin
                    cur_phase  = PH_DIGITS;
                    cur_base   = BASE_DEC;
                    part_value = 33'(digit);
                end else begin
                    bad_text = 1'b1;
                end
            end
            PH_ZERO: begin
                if (c == CH_LOW_X || c == CH_UP_X) begin
                    cur_phase = PH_PREFIX;
                    cur_base  = BASE_HEX;
                end else if (digit <= 7) begin
                    cur_phase  = PH_DIGITS;
                    part_value = 33'(digit);
                end else begin
                    bad_text = 1'b1;
                end
            end
            PH_PREFIX: begin
                if (digit <= 15) begin
                    cur_phase  = PH_DIGITS;
                    part_value = 33'(digit);
                end else begin
                    bad_text = 1'b1;
                end
            end
            default: begin
                if (digit <= top_digit(cur_base)) add_digit(digit);
                else bad_text = 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 100) begin
            $display("%0t: mismatch in %s: got %08h, expected %08h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = src_pace_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= c;
        @(posedge i_clk);
        while (!char_if.ready) @(posedge i_clk);
        scan_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
        send_char(CH_NUL);
    endtask

    function automatic string number_text(input longint unsigned v);
        string s;
        string prefix;
        case ($urandom_range(0, 2))
            0: s = $sformatf("%0d", v);
            1: s = {"0", $sformatf("%0o", v)};
            default: begin
                s = $sformatf("%0h", v);
                if ($urandom_range(0, 1)) s = s.toupper();
                if ($urandom_range(0, 1)) prefix = "0X";
                else prefix = "0x";
                s = {prefix, s};
            end
        endcase
        return s;
    endfunction

    function automatic longint unsigned pick_part(input logic [31:0] limit);
        longint unsigned huge;
        huge = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0: return 0;
            1: return limit;
            2: return {32'd0, limit} + 64'd1;
            3: return huge >> $urandom_range(0, 31);
            default: return $urandom_range(0, limit);
        endcase
    endfunction

    function automatic string make_address();
        string       text;
        string       sep;
        int          n;
        logic [31:0] tail_limit;
        n = $urandom_range(1, 4);
        case (n)
            1: tail_limit = 32'hFFFF_FFFF;
            2: tail_limit = LIMIT_24;
            3: tail_limit = LIMIT_16;
            default: tail_limit = LIMIT_8;
        endcase
        text = "";
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                if ($urandom_range(0, 3) == 0) sep = ":";
                else sep = ".";
                text = {text, sep};
            end
            case ($urandom_range(0, 11))
                0: text = {text, " "};
                1: text = {text, " \t "};
                default: ;
            endcase
            if (i == n - 1) text = {text, number_text(pick_part(tail_limit))};
            else text = {text, number_text(pick_part(LIMIT_8))};
        end
        case ($urandom_range(0, 7))
            0: text = {text, " 9.x-junk"};
            1: text = {text, "\t"};
            default: ;
        endcase
        return text;
    endfunction

    function automatic string break_text(input string s);
        int    k;
        string piece;
        k = $urandom_range(0, s.len());
        case ($urandom_range(0, 2))
            0: piece = $sformatf("%c", 8'($urandom_range(1, 255)));
            1: piece = ".";
            default: begin
                piece = "";
                if (k == s.len()) k--;
                return {s.substr(0, k - 1), s.substr(k + 1, s.len() - 1)};
            end
        endcase
        return {s.substr(0, k - 1), piece, s.substr(k, s.len() - 1)};
    endfunction

    task automatic test_directed_cases();
        string cases[$];
        cases = '{"", "0", "4294967295", "4294967296", "037777777777", "0XfFfFfFfF",
                  "0x100000000", "0x", "0x 1", "08", "0x1g", "+1", "-1", "1.16777215",
                  "255.16777216", "256.1", "1.2.65535", "1.2.3.256", "10.20.30.40",
                  "0:0xA:012:255", "1.2.3.4.5", "1..2", "1.", " \t 127. 0.0.1",
                  "12 trailing.junk"};
        cases.push_back($sformatf("%c%c7%cx", 8'd11, 8'd12, 8'd13));
        cases.push_back($sformatf("%c", 8'd10));
        cases.push_back($sformatf("%c1", 8'd8));
        cases.push_back($sformatf("1%c", 8'd14));
        foreach (cases[i]) begin
            src_pace_on = $urandom_range(0, 1);
            send_text(cases[i]);
        end
    endtask

    task automatic test_well_formed_addresses(input int budget);
        while (chars_sent < budget) begin
            src_pace_on = $urandom_range(0, 3) != 0;
            send_text(make_address());
        end
    endtask

    task automatic test_broken_and_noise(input int budget);
        string charset;
        int    n;
        charset = "0123456789abcdefABCDEFxX.: \t+-";
        while (chars_sent < budget) begin
            src_pace_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 2) != 0) begin
                send_text(break_text(make_address()));
            end else begin
                n = $urandom_range(0, 10);
                repeat (n) begin
                    if ($urandom_range(0, 1)) begin
                        send_char(charset[$urandom_range(0, charset.len() - 1)]);
                    end else begin
                        send_char(8'($urandom_range(0, 255)));
                    end
                end
                send_char(CH_NUL);
            end
        end
    endtask

    task automatic test_output_backpressure(input int budget);
        src_pace_on = 1'b0;
        hold_off_cycles = HOLD_CYCLES;
        repeat (4) send_text(make_address());
        while (chars_sent < budget) begin
            src_pace_on = $urandom_range(0, 1);
            send_text(make_address());
        end
    endtask

    initial begin : result_taker
        int stall;
        addr_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = snk_pace_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall > 0) begin
                addr_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            addr_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!addr_if.valid) @(posedge i_clk);
            if ($urandom_range(0, 15) == 0) snk_pace_on = !snk_pace_on;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_pack_result want;
        if (i_rst_n && addr_if.valid && addr_if.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result transaction", addr_if.address, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (addr_if.address !== want.address) begin
                    report_mismatch("address", addr_if.address, want.address);
                end
                if (addr_if.valid_res !== want.ok) begin
                    report_mismatch("valid_res", 32'(addr_if.valid_res), 32'(want.ok));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (char_if.valid && char_if.ready) || (addr_if.valid && addr_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        char_if.valid = 1'b0;
        char_if.char_code = CH_NUL;
        clear_scanner();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_well_formed_addresses(550);
        test_broken_and_noise(780);
        test_output_backpressure(950);

        char_if.valid <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/dip_pkg.sv
sv/dip_char_if.sv
sv/dip_addr_if.sv
sv/dip_scan.sv
sv/dip_pack.sv
sv/dotted_ipv4_address_parser_top.sv
verif/testbench.sv
